// File: design/raft_peer_progress_tracker_unit_assert.svh
// Assertion macros for the peer progress tracker
`ifndef RAFT_PEER_PROGRESS_TRACKER_UNIT_ASSERT_SVH
`define RAFT_PEER_PROGRESS_TRACKER_UNIT_ASSERT_SVH

`define RPPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RPPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rppt_pkg.sv
`timescale 1ns / 1ps
package rppt_pkg;
    localparam int MaxPeers    = 16;
    localparam int WindowDepth = 16;
    localparam int IndexBits   = 64;
    localparam int SlotBits    = $clog2(MaxPeers);
    localparam int WinBits     = $clog2(WindowDepth);
    localparam int FillBits    = $clog2(WindowDepth + 1);
    localparam int CntBits     = $clog2(MaxPeers + 1);
    localparam int RingDepth   = MaxPeers * WindowDepth;
    localparam int RingBits    = $clog2(RingDepth);

    localparam logic [IndexBits-1:0] IdxMax = '1;

    localparam logic [2:0] EV_SENT   = 3'd0;
    localparam logic [2:0] EV_OPT    = 3'd1;
    localparam logic [2:0] EV_REPL   = 3'd2;
    localparam logic [2:0] EV_REJ    = 3'd3;
    localparam logic [2:0] EV_SNAP   = 3'd4;
    localparam logic [2:0] EV_COMMIT = 3'd5;
    localparam logic [2:0] EV_ACTIVE = 3'd6;

    localparam logic [1:0] PM_PROBE = 2'd0;
    localparam logic [1:0] PM_REPL  = 2'd1;
    localparam logic [1:0] PM_SNAP  = 2'd2;

    localparam logic [1:0] CFG_PEERS = 2'd0;
    localparam logic [1:0] CFG_NEXT  = 2'd1;
    localparam logic [1:0] CFG_CAP   = 2'd2;

    // peer record: next, match, pending snapshot, head, fill, mode, active
    localparam int RecBits = 3 * IndexBits + WinBits + FillBits + 3;

    typedef struct packed {
        logic [IndexBits-1:0] next_idx;
        logic [IndexBits-1:0] match_idx;
        logic [IndexBits-1:0] pend_snap;
        logic [WinBits-1:0]   head;
        logic [FillBits-1:0]  fill;
        logic [1:0]           pmode;
        logic                 active;
    } t_rec;

    typedef struct packed {
        logic [2:0]           mode;
        logic [3:0]           peer_slot;
        logic [IndexBits-1:0] log_index_in;
        logic [IndexBits-1:0] hint_index;
        logic [4:0]           quorum_size;
    } t_in;

    typedef struct packed {
        logic                 peer_found;
        logic [1:0]           peer_mode;
        logic [IndexBits-1:0] next_index_out;
        logic [IndexBits-1:0] match_index_out;
        logic [IndexBits-1:0] pending_snapshot_out;
        logic                 active_out;
        logic [4:0]           inflight_count;
        logic [IndexBits-1:0] commit_index;
        logic [4:0]           active_count;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_EXEC, ST_FREE_RD, ST_FREE_CHK,
        ST_WB, ST_SCAN_RD, ST_SCAN, ST_RANK, ST_DONE
    } t_state;

    function automatic logic [IndexBits-1:0] sat_inc(input logic [IndexBits-1:0] v);
        return (v == IdxMax) ? IdxMax : v + 1'b1;
    endfunction

    function automatic logic [IndexBits-1:0] max_idx(input logic [IndexBits-1:0] a,
                                                    input logic [IndexBits-1:0] b);
        return (a > b) ? a : b;
    endfunction
endpackage

// File: design/raft_peer_progress_tracker_unit.sv
`timescale 1ns / 1ps
// Per-peer replication progress table. Peer records and in-flight windows
// live in two RAMs with registered reads; after reset or a write to the peer
// count, initial next index or window capacity register a clearing pass over
// every record runs, during which no transfer is taken. One item is in flight
// at a time and its result is registered; the input stalls while that result
// waits. Sent, optimistic, rejected and snapshot events read, update and write
// back the peer record; a slot at or above the peer count is not found. A
// replicated acknowledgement also frees window entries from the head until
// one is above the acknowledged index or the window is empty. The active count
// and commit queries scan every peer record; the commit query then picks the
// largest remaining value once per quorum member.
module raft_peer_progress_tracker_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rppt_pkg::t_in           i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rppt_pkg::t_out          o_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data
);
    import rppt_pkg::*;
    `include "raft_peer_progress_tracker_unit_assert.svh"

    t_state r_state, n_state;
    logic [CntBits-1:0]   r_peers;
    logic [IndexBits-1:0] r_init_next;
    logic [FillBits-1:0]  r_cap;
    t_in                  r_in;
    t_rec                 r_rec;
    logic [SlotBits:0]    r_cnt;
    logic [CntBits-1:0]   r_nvals;
    logic [IndexBits-1:0] r_vals [MaxPeers+1];
    logic [MaxPeers:0]    r_taken;
    logic [IndexBits-1:0] r_best;
    logic [CntBits-1:0]   r_best_i;
    logic [4:0]           r_rank;
    logic [4:0]           r_act;
    logic                 r_ovalid;
    t_out                 r_out;

    logic                 rec_we;
    logic [SlotBits-1:0]  rec_waddr, rec_raddr;
    t_rec                 rec_wdata, rec_rdata;
    logic [RecBits-1:0]   rec_rraw;
    logic                 ring_we;
    logic [RingBits-1:0]  ring_waddr, ring_raddr;
    logic [IndexBits-1:0] ring_wdata, ring_rdata;

    rppt_ram #(.Width(RecBits), .Depth(MaxPeers)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(rec_wdata),
        .i_raddr(rec_raddr), .o_rdata(rec_rraw)
    );
    assign rec_rdata = t_rec'(rec_rraw);

    rppt_ram #(.Width(IndexBits), .Depth(RingDepth)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(ring_waddr), .i_wdata(ring_wdata),
        .i_raddr(ring_raddr), .o_rdata(ring_rdata)
    );

    logic out_free, in_acc, cfg_acc, cfg_hit;
    logic slot_ok;
    logic [SlotBits-1:0] slot;
    t_rec exec_rec;
    logic do_add;
    logic [WinBits-1:0] tail;

    assign out_free    = !r_ovalid || !i_stall;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_acc && (i_cfg_index == CFG_PEERS || i_cfg_index == CFG_NEXT
                                     || i_cfg_index == CFG_CAP);
    assign o_stall     = !(r_state == ST_IDLE && out_free && !cfg_hit);
    assign in_acc      = i_valid && !o_stall;
    assign slot        = r_in.peer_slot[SlotBits-1:0];
    assign slot_ok     = {1'b0, r_in.peer_slot} < 5'(r_peers);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    // event update on the fetched record (window freeing follows separately)
    always_comb begin
        exec_rec = rec_rdata;
        do_add   = 1'b0;
        unique case (r_in.mode)
            EV_SENT: begin
                exec_rec.active = 1'b1;
                if (r_in.log_index_in != '0 && rec_rdata.pmode == PM_REPL) begin
                    exec_rec.next_idx = max_idx(rec_rdata.next_idx, sat_inc(r_in.log_index_in));
                    if (r_cap != '0) begin
                        do_add = 1'b1;
                        if (rec_rdata.fill >= r_cap) begin
                            exec_rec.head = rec_rdata.head + 1'b1;
                        end else begin
                            exec_rec.fill = rec_rdata.fill + 1'b1;
                        end
                    end
                end
            end
            EV_OPT: begin
                if (r_in.log_index_in != '0) begin
                    exec_rec.next_idx = max_idx(rec_rdata.next_idx, sat_inc(r_in.log_index_in));
                end
            end
            EV_REPL: begin
                exec_rec.match_idx = max_idx(rec_rdata.match_idx, r_in.log_index_in);
                exec_rec.next_idx  = max_idx(rec_rdata.next_idx, sat_inc(exec_rec.match_idx));
                exec_rec.pend_snap = '0;
                exec_rec.pmode     = PM_REPL;
                exec_rec.active    = 1'b1;
            end
            EV_REJ: begin
                exec_rec.pmode  = PM_PROBE;
                exec_rec.head   = '0;
                exec_rec.fill   = '0;
                exec_rec.active = 1'b1;
                if (r_in.hint_index != '0) begin
                    exec_rec.next_idx = r_in.hint_index;
                end else if (r_in.log_index_in > IndexBits'(1)) begin
                    exec_rec.next_idx = r_in.log_index_in - 1'b1;
                end else begin
                    exec_rec.next_idx = IndexBits'(1);
                end
            end
            default: begin
                exec_rec.pmode     = PM_SNAP;
                exec_rec.pend_snap = r_in.log_index_in;
                exec_rec.head      = '0;
                exec_rec.fill      = '0;
            end
        endcase
    end

    assign tail = rec_rdata.head + WinBits'(rec_rdata.fill);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_cnt == (SlotBits+1)'(MaxPeers - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (cfg_hit) begin
                    n_state = ST_CLEAR;
                end else if (in_acc) begin
                    if (i_data.mode <= EV_SNAP) begin
                        n_state = ST_RD;
                    end else if (i_data.mode == EV_COMMIT || i_data.mode == EV_ACTIVE) begin
                        n_state = ST_SCAN_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD:       n_state = slot_ok ? ST_EXEC : ST_DONE;
            ST_EXEC:     n_state = (r_in.mode == EV_REPL) ? ST_FREE_RD : ST_DONE;
            ST_FREE_RD:  n_state = (r_rec.fill == '0) ? ST_WB : ST_FREE_CHK;
            ST_FREE_CHK: n_state = (ring_rdata <= r_in.log_index_in) ? ST_FREE_RD : ST_WB;
            ST_WB:       n_state = ST_DONE;
            ST_SCAN_RD:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_cnt >= (SlotBits+1)'(r_peers)) begin
                    if (r_in.mode == EV_ACTIVE || r_in.quorum_size == '0
                        || r_in.quorum_size > 5'(r_nvals)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RANK;
                    end
                end
            end
            ST_RANK: begin
                if (r_cnt == (SlotBits+1)'(r_nvals) && r_rank == r_in.quorum_size - 5'd1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        rec_we     = 1'b0;
        rec_waddr  = slot;
        rec_wdata  = r_rec;
        rec_raddr  = slot;
        ring_we    = 1'b0;
        ring_waddr = {slot, tail};
        ring_wdata = r_in.log_index_in;
        ring_raddr = {slot, r_rec.head};
        unique case (r_state)
            ST_CLEAR: begin
                rec_we    = 1'b1;
                rec_waddr = r_cnt[SlotBits-1:0];
                rec_wdata = '{next_idx: r_init_next, match_idx: '0, pend_snap: '0,
                              head: '0, fill: '0, pmode: PM_PROBE, active: 1'b0};
            end
            ST_IDLE:  rec_raddr = i_data.peer_slot[SlotBits-1:0];
            ST_EXEC: begin
                ring_we = do_add;
                if (r_in.mode != EV_REPL) begin
                    rec_we    = 1'b1;
                    rec_wdata = exec_rec;
                end
            end
            ST_WB: rec_we = 1'b1;
            ST_SCAN_RD, ST_SCAN: rec_raddr = r_cnt[SlotBits-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_peers     <= '0;
            r_init_next <= IndexBits'(1);
            r_cap       <= FillBits'(WindowDepth);
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
            r_in        <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: r_cnt <= r_cnt + 1'b1;
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (cfg_hit) begin
                        unique case (i_cfg_index)
                            CFG_PEERS: r_peers <= (i_cfg_data[4:0] > 5'(MaxPeers))
                                ? CntBits'(MaxPeers) : CntBits'(i_cfg_data[4:0]);
                            CFG_NEXT:  r_init_next <= i_cfg_data[IndexBits-1:0];
                            default:   r_cap <= (i_cfg_data[4:0] > 5'(WindowDepth))
                                ? FillBits'(WindowDepth) : FillBits'(i_cfg_data[4:0]);
                        endcase
                    end else if (in_acc) begin
                        r_in  <= i_data;
                        r_out <= '0;
                    end
                    r_act   <= '0;
                    r_taken <= '0;
                    r_rank  <= '0;
                    r_best  <= '0;
                    r_best_i <= '0;
                end
                ST_EXEC: r_rec <= exec_rec;
                ST_FREE_RD: ;
                ST_FREE_CHK: begin
                    if (ring_rdata <= r_in.log_index_in) begin
                        r_rec.head <= r_rec.head + 1'b1;
                        r_rec.fill <= r_rec.fill - 1'b1;
                    end
                end
                ST_SCAN_RD: begin
                    r_cnt      <= r_cnt + 1'b1;
                    r_vals[0]  <= r_in.log_index_in;
                    r_nvals    <= CntBits'(r_peers) + 1'b1;
                end
                ST_SCAN: begin
                    if (r_cnt <= (SlotBits+1)'(r_peers) && r_cnt != '0) begin
                        r_vals[r_cnt] <= rec_rdata.match_idx;
                        r_act <= r_act + 5'(rec_rdata.active);
                    end
                    r_cnt <= (r_cnt >= (SlotBits+1)'(r_peers)) ? '0 : r_cnt + 1'b1;
                end
                ST_RANK: begin
                    if (r_cnt == (SlotBits+1)'(r_nvals)) begin
                        r_taken[r_best_i] <= 1'b1;
                        r_rank   <= r_rank + 1'b1;
                        r_out.commit_index <= r_best;
                        r_best   <= '0;
                        r_best_i <= '0;
                        r_cnt    <= '0;
                    end else begin
                        if (!r_taken[r_cnt] && (r_vals[r_cnt] > r_best || r_best_i == '0
                            && r_taken[0] && r_best == '0 || r_cnt == '0)) begin
                            r_best   <= r_vals[r_cnt];
                            r_best_i <= CntBits'(r_cnt);
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: begin
                    r_ovalid <= 1'b1;
                    if (r_in.mode <= EV_SNAP && slot_ok) begin
                        r_out.peer_found <= 1'b1;
                        r_out.peer_mode  <= r_rec.pmode;
                        r_out.next_index_out <= r_rec.next_idx;
                        r_out.match_index_out <= r_rec.match_idx;
                        r_out.pending_snapshot_out <= r_rec.pend_snap;
                        r_out.active_out <= r_rec.active;
                        r_out.inflight_count <= 5'(r_rec.fill);
                    end
                    if (r_in.mode == EV_ACTIVE) r_out.active_count <= r_act;
                end
                default: ;
            endcase
            if (r_state == ST_RD && slot_ok) r_rec <= rec_rdata;
        end
    end

    // ring entry read before compare: ST_FREE_RD issues the head address
    `RPPT_ASSERT_NXT(a_free_chk, i_clk, i_rst_n, r_state == ST_FREE_CHK,
        r_state == ST_FREE_RD || r_state == ST_WB, "window free sequence broken")
    `RPPT_ASSERT_IMP(a_fill_cap, i_clk, i_rst_n, r_state == ST_WB,
        r_rec.fill <= FillBits'(WindowDepth), "window fill above depth")
    `RPPT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE,
        o_stall && !o_cfg_ready, "transfer taken while busy")
    `RPPT_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE,
        o_valid, "result lost")
endmodule

// File: design/rppt_ram.sv
`timescale 1ns / 1ps
module rppt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
